### rtl/utf8v_pkg.sv
// Shared types, constants and helpers for the UTF-8 text validator.
`timescale 1ns / 1ps

package utf8v_pkg;

  localparam int CpWidth = 21;

  localparam logic [7:0] LeadAsciiMax = 8'h7f;
  localparam logic [7:0] Lead2Min     = 8'hc2;
  localparam logic [7:0] Lead2Max     = 8'hdf;
  localparam logic [7:0] Lead3Min     = 8'he0;
  localparam logic [7:0] Lead3Max     = 8'hef;
  localparam logic [7:0] Lead4Min     = 8'hf0;
  localparam logic [7:0] Lead4Max     = 8'hf4;
  localparam logic [7:0] ContMask     = 8'hc0;
  localparam logic [7:0] ContTag      = 8'h80;

  localparam logic [1:0] SeqTwo   = 2'd1;
  localparam logic [1:0] SeqThree = 2'd2;
  localparam logic [1:0] SeqFour  = 2'd3;

  localparam logic [CpWidth-1:0] CpNul        = 21'h000000;
  localparam logic [CpWidth-1:0] CpTab        = 21'h000009;
  localparam logic [CpWidth-1:0] CpLf         = 21'h00000a;
  localparam logic [CpWidth-1:0] CpCr         = 21'h00000d;
  localparam logic [CpWidth-1:0] CpSpace      = 21'h000020;
  localparam logic [CpWidth-1:0] CpDel        = 21'h00007f;
  localparam logic [CpWidth-1:0] CpC1Min      = 21'h000080;
  localparam logic [CpWidth-1:0] CpC1Max      = 21'h00009f;
  localparam logic [CpWidth-1:0] CpThreeMin   = 21'h000800;
  localparam logic [CpWidth-1:0] CpSurrMin    = 21'h00d800;
  localparam logic [CpWidth-1:0] CpSurrMax    = 21'h00dfff;
  localparam logic [CpWidth-1:0] CpFourMin    = 21'h010000;
  localparam logic [CpWidth-1:0] CpMax        = 21'h10ffff;

  typedef struct packed {
    logic               error_seen;
    logic [1:0]         bytes_pending;
    logic [1:0]         sequence_length;
    logic [CpWidth-1:0] partial_code_point;
  } dec_state_t;

  localparam dec_state_t DecStateReset = '{
    error_seen: 1'b0,
    bytes_pending: 2'd0,
    sequence_length: 2'd0,
    partial_code_point: '0
  };

  function automatic logic forbidden_control(input logic [CpWidth-1:0] cp);
    logic bad;
    bad = (cp == CpNul) || (cp == CpDel);
    if (cp < CpSpace && cp != CpTab && cp != CpLf && cp != CpCr) begin
      bad = 1'b1;
    end
    if (cp >= CpC1Min && cp <= CpC1Max) begin
      bad = 1'b1;
    end
    return bad;
  endfunction

endpackage

### rtl/utf8v_in_if.sv
// Byte channel into the validator: one string byte and its end flag.
`timescale 1ns / 1ps

interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/utf8v_out_if.sv
// Verdict channel out of the validator.
`timescale 1ns / 1ps

interface utf8v_out_if;
  logic valid;
  logic ready;
  logic text_valid;

  modport source (output valid, output text_valid, input ready);
  modport sink (input valid, input text_valid, output ready);
endinterface

### rtl/utf8_text_validator_core.sv
// Top level of the streaming strict UTF-8 text validator.
`timescale 1ns / 1ps

// Streams a string one byte per word; the word flagged last_byte yields one
// verdict word (text_valid = 1 for acceptable strict UTF-8 text without
// forbidden controls). Bytes are taken one per cycle: each word is held in
// an input register, decoded against the running state combinationally, and the
// verdict is then registered in an output register.
// Throughput is one byte per cycle; only a final byte waits while a previous
// verdict is still untaken. Decoder state clears after every final byte.

module utf8_text_validator_core
  import utf8v_pkg::*;
(
  input logic        clk,
  input logic        rst,
  utf8v_in_if.sink   text,
  utf8v_out_if.source verdict
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       proc;

  dec_state_t state;
  dec_state_t state_step;
  logic       step_verdict;

  logic       out_valid;
  logic       out_valid_next;
  logic       out_text;

  utf8v_step u_step (
    .cur       (state),
    .data_byte (s1_byte),
    .nxt       (state_step),
    .verdict   (step_verdict)
  );

  assign proc       = s1_valid && (!s1_last || !out_valid || verdict.ready);
  assign text.ready = !s1_valid || proc;

  assign out_valid_next = (proc && s1_last) || (out_valid && !verdict.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
    if (text.ready && text.valid) begin
      s1_byte <= text.data_byte;
      s1_last <= text.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= DecStateReset;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (proc) begin
        state <= s1_last ? DecStateReset : state_step;
      end
    end
    if (proc && s1_last) begin
      out_text <= step_verdict;
    end
  end

  assign verdict.valid      = out_valid;
  assign verdict.text_valid = out_text;

  // a final byte leaves the decoder clean for the next string
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    proc && s1_last |=> !state.error_seen && state.bytes_pending == 2'd0)
    else $error("decoder state not cleared after final byte");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    state.bytes_pending != 2'd0 |->
      state.sequence_length != 2'd0 && state.bytes_pending <= state.sequence_length)
    else $error("pending count exceeds sequence length");

  a_error_idle: assert property (@(posedge clk) disable iff (rst)
    state.error_seen |-> state.bytes_pending == 2'd0)
    else $error("sequence still pending after error");

  a_verdict_from_last: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(proc && s1_last) |=> !out_valid)
    else $error("verdict raised without a final byte");

endmodule

### rtl/utf8v_step.sv
// Per-byte decode step: next decoder state and verdict for one byte.
`timescale 1ns / 1ps

module utf8v_step
  import utf8v_pkg::*;
(
  input  dec_state_t cur,
  input  logic [7:0] data_byte,
  output dec_state_t nxt,
  output logic       verdict
);

  logic [CpWidth-1:0] cp_cont;
  logic [CpWidth-1:0] cp_lead;

  assign cp_cont = {cur.partial_code_point[CpWidth-7:0], data_byte[5:0]};
  assign cp_lead = {{(CpWidth-8){1'b0}}, data_byte};

  always_comb begin
    nxt = cur;
    if (!cur.error_seen) begin
      if (cur.bytes_pending == 2'd0) begin
        if (data_byte <= LeadAsciiMax) begin
          if (forbidden_control(cp_lead)) begin
            nxt.error_seen = 1'b1;
          end
        end else if (data_byte >= Lead2Min && data_byte <= Lead2Max) begin
          nxt.bytes_pending      = SeqTwo;
          nxt.sequence_length    = SeqTwo;
          nxt.partial_code_point = {{(CpWidth-5){1'b0}}, data_byte[4:0]};
        end else if (data_byte >= Lead3Min && data_byte <= Lead3Max) begin
          nxt.bytes_pending      = SeqThree;
          nxt.sequence_length    = SeqThree;
          nxt.partial_code_point = {{(CpWidth-4){1'b0}}, data_byte[3:0]};
        end else if (data_byte >= Lead4Min && data_byte <= Lead4Max) begin
          nxt.bytes_pending      = SeqFour;
          nxt.sequence_length    = SeqFour;
          nxt.partial_code_point = {{(CpWidth-3){1'b0}}, data_byte[2:0]};
        end else begin
          nxt.error_seen = 1'b1;
        end
      end else if ((data_byte & ContMask) != ContTag) begin
        nxt.error_seen    = 1'b1;
        nxt.bytes_pending = 2'd0;
      end else begin
        nxt.partial_code_point = cp_cont;
        nxt.bytes_pending      = cur.bytes_pending - 2'd1;
        if (cur.bytes_pending == 2'd1) begin
          case (cur.sequence_length)
            SeqThree: begin
              if (cp_cont < CpThreeMin || (cp_cont >= CpSurrMin && cp_cont <= CpSurrMax)) begin
                nxt.error_seen = 1'b1;
              end
            end
            SeqFour: begin
              if (cp_cont < CpFourMin || cp_cont > CpMax) begin
                nxt.error_seen = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (forbidden_control(cp_cont)) begin
            nxt.error_seen = 1'b1;
          end
        end
      end
    end
  end

  assign verdict = !nxt.error_seen && (nxt.bytes_pending == 2'd0);

endmodule

### test/tb_utf8_text_validator_core.sv
// Self-checking testbench for the streaming strict UTF-8 text validator.
`timescale 1ns / 1ps

module tb_utf8_text_validator_core
  import utf8v_pkg::*;
();

  localparam int IdleLimit   = 500;
  localparam int RandomWords = 550;
  localparam int TailCycles  = 8;

  typedef enum int {
    FaultNone,
    FaultRawSeq,
    FaultRandByte,
    FaultControl,
    FaultBadCont,
    FaultTruncate,
    FaultC1Pair,
    FaultNoise
  } fault_e;

  logic clk = 1'b0;
  logic rst;

  utf8v_in_if  text_if ();
  utf8v_out_if verdict_if ();

  utf8_text_validator_core dut (
    .clk     (clk),
    .rst     (rst),
    .text    (text_if),
    .verdict (verdict_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder shadow state
  logic               dec_bad  = 1'b0;
  logic [1:0]         dec_need = '0;
  logic [1:0]         dec_kind = '0;
  logic [CpWidth-1:0] dec_cp   = '0;

  logic expected_verdicts[$];
  logic [7:0] str_q[$];
  logic want_verdict;

  int fail_count    = 0;
  int words_sent    = 0;
  int finals_sent   = 0;
  int verdicts_seen = 0;
  int idle_cycles   = 0;
  int burst_left    = 0;
  int run_left      = 0;
  int stall_left    = 0;

  logic [CpWidth-1:0] cp_bounds[13] = '{
    CpTab, CpLf, CpCr, 21'h20, 21'h7e, 21'ha0, 21'h7ff, 21'h800,
    21'hd7ff, 21'he000, 21'hffff, 21'h10000, CpMax
  };

  function automatic logic banned_cp(input logic [CpWidth-1:0] cp);
    return (cp == CpNul) || (cp == CpDel) ||
           (cp < CpSpace && cp != CpTab && cp != CpLf && cp != CpCr) ||
           (cp >= CpC1Min && cp <= CpC1Max);
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic lst);
    logic [CpWidth-1:0] cp;
    if (!dec_bad) begin
      if (dec_need == 2'd0) begin
        if (b <= LeadAsciiMax) begin
          if (banned_cp({13'd0, b})) dec_bad = 1'b1;
        end else if (b >= Lead2Min && b <= Lead2Max) begin
          dec_need = SeqTwo;
          dec_kind = SeqTwo;
          dec_cp   = {16'd0, b[4:0]};
        end else if (b >= Lead3Min && b <= Lead3Max) begin
          dec_need = SeqThree;
          dec_kind = SeqThree;
          dec_cp   = {17'd0, b[3:0]};
        end else if (b >= Lead4Min && b <= Lead4Max) begin
          dec_need = SeqFour;
          dec_kind = SeqFour;
          dec_cp   = {18'd0, b[2:0]};
        end else begin
          dec_bad = 1'b1;
        end
      end else if ((b & ContMask) != ContTag) begin
        dec_bad  = 1'b1;
        dec_need = 2'd0;
      end else begin
        cp       = {dec_cp[CpWidth-7:0], b[5:0]};
        dec_cp   = cp;
        dec_need = dec_need - 2'd1;
        if (dec_need == 2'd0) begin
          if (dec_kind == SeqThree &&
              (cp < CpThreeMin || (cp >= CpSurrMin && cp <= CpSurrMax))) dec_bad = 1'b1;
          if (dec_kind == SeqFour && (cp < CpFourMin || cp > CpMax)) dec_bad = 1'b1;
          if (banned_cp(cp)) dec_bad = 1'b1;
        end
      end
    end
    if (lst) begin
      expected_verdicts.push_back(!dec_bad && dec_need == 2'd0);
      dec_bad  = 1'b0;
      dec_need = '0;
      dec_kind = '0;
      dec_cp   = '0;
    end
  endtask

  // result check, shadow decode on accepted input words, stall watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (verdict_if.valid && verdict_if.ready) begin
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          $error("text_valid: no verdict expected, actual %0b", verdict_if.text_valid);
          fail_count++;
        end else begin
          want_verdict = expected_verdicts.pop_front();
          if (verdict_if.text_valid !== want_verdict) begin
            $error("text_valid: expected %0b, actual %0b", want_verdict,
                   verdict_if.text_valid);
            fail_count++;
          end
        end
      end
      if (text_if.valid && text_if.ready) decode_byte(text_if.data_byte, text_if.last_byte);
      if ((text_if.valid && text_if.ready) || (verdict_if.valid && verdict_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // verdict sink: runs of ready broken by short or long stalls
  always @(posedge clk) begin
    if (rst) begin
      verdict_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      verdict_if.ready <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      verdict_if.ready <= 1'b1;
    end else begin
      run_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 30);
      stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      verdict_if.ready <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (burst_left == 0) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
    end
    burst_left--;
    text_if.valid     <= 1'b1;
    text_if.data_byte <= b;
    text_if.last_byte <= lst;
    do @(posedge clk); while (!text_if.ready);
    words_sent++;
    if (lst) finals_sent++;
  endtask

  task automatic send_string();
    int i;
    for (i = 0; i < str_q.size(); i++) send_byte(str_q[i], i == str_q.size() - 1);
  endtask

  task automatic wait_for_drain();
    text_if.valid <= 1'b0;
    do @(posedge clk); while (verdicts_seen < finals_sent);
  endtask

  task automatic push_cp(input logic [CpWidth-1:0] cp);
    if (cp < CpC1Min) begin
      str_q.push_back(cp[7:0]);
    end else if (cp < CpThreeMin) begin
      str_q.push_back({3'b110, cp[10:6]});
      str_q.push_back({2'b10, cp[5:0]});
    end else if (cp < CpFourMin) begin
      str_q.push_back({4'b1110, cp[15:12]});
      str_q.push_back({2'b10, cp[11:6]});
      str_q.push_back({2'b10, cp[5:0]});
    end else begin
      str_q.push_back({5'b11110, cp[20:18]});
      str_q.push_back({2'b10, cp[17:12]});
      str_q.push_back({2'b10, cp[11:6]});
      str_q.push_back({2'b10, cp[5:0]});
    end
  endtask

  function automatic logic [CpWidth-1:0] pick_text_cp();
    logic [CpWidth-1:0] cp;
    if ($urandom_range(0, 7) == 0) return cp_bounds[$urandom_range(0, $size(cp_bounds) - 1)];
    case ($urandom_range(0, 3))
      0: cp = 21'($urandom_range(32'h20, 32'h7e));
      1: cp = 21'($urandom_range(32'ha0, 32'h7ff));
      2: begin
        cp = 21'($urandom_range(32'h800, 32'hffff));
        if (cp >= CpSurrMin && cp <= CpSurrMax) cp = cp - 21'h800;
      end
      default: cp = 21'($urandom_range(32'h10000, 32'h10ffff));
    endcase
    return cp;
  endfunction

  task automatic push_fault(input fault_e kind);
    int base;
    logic [7:0] b;
    case (kind)
      FaultRawSeq: begin
        str_q.push_back(8'($urandom_range(8'h80, 8'hff)));
        repeat ($urandom_range(0, 3)) str_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
      end
      FaultRandByte: str_q.push_back(8'($urandom_range(0, 255)));
      FaultControl: begin
        b = 8'($urandom_range(0, 32));
        str_q.push_back((b == 8'd32) ? LeadAsciiMax : b);
      end
      FaultBadCont: begin
        base = str_q.size();
        push_cp(21'($urandom_range(32'h80, 32'h10ffff)));
        str_q[$urandom_range(base + 1, str_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
      FaultC1Pair: begin
        str_q.push_back(Lead2Min);
        str_q.push_back(8'($urandom_range(8'h80, 8'h9f)));
      end
      default: repeat ($urandom_range(1, 8)) str_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  // mostly clean text, some strings carry one fault
  task automatic build_random_text();
    int n_chars, fault_at, base, i;
    fault_e fault;
    str_q.delete();
    n_chars  = $urandom_range(1, 6);
    fault    = ($urandom_range(0, 9) < 7) ? FaultNone : fault_e'($urandom_range(1, 7));
    fault_at = $urandom_range(0, n_chars - 1);
    for (i = 0; i < n_chars; i++) begin
      if (i == fault_at && fault != FaultNone && fault != FaultTruncate) push_fault(fault);
      else push_cp(pick_text_cp());
    end
    if (fault == FaultTruncate) begin
      base = str_q.size();
      push_cp(21'($urandom_range(32'h80, 32'h10ffff)));
      repeat ($urandom_range(1, str_q.size() - base - 1)) void'(str_q.pop_back());
    end
  endtask

  task automatic test_boundary_strings();
    str_q = '{8'h41};                      send_string();
    str_q = '{8'h00};                      send_string();
    str_q = '{8'h7f};                      send_string();
    str_q = '{8'hff};                      send_string();
    str_q = '{8'h09, 8'h0a, 8'h0d};        send_string();
    str_q = '{8'hc2, 8'h80};               send_string();
    str_q = '{8'he0, 8'h9f, 8'hbf};        send_string();
    str_q = '{8'hed, 8'ha0, 8'h80};        send_string();
    str_q = '{8'hf4, 8'h90, 8'h80, 8'h80}; send_string();
    // cut short by the end of the string
    str_q = '{8'he2, 8'h82};               send_string();
    // non-continuation byte inside a sequence, later bytes ignored
    str_q = '{8'hc3, 8'h41, 8'h42};        send_string();
  endtask

  task automatic test_random_text();
    while (words_sent < RandomWords) begin
      build_random_text();
      send_string();
    end
  endtask

  task automatic test_pause_for_drain();
    repeat (4) begin
      repeat ($urandom_range(1, 3)) begin
        build_random_text();
        send_string();
      end
      wait_for_drain();
    end
  endtask

  initial begin
    rst                <= 1'b1;
    text_if.valid      <= 1'b0;
    text_if.data_byte  <= '0;
    text_if.last_byte  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_boundary_strings();
    test_pause_for_drain();
    test_random_text();

    wait_for_drain();
    repeat (TailCycles) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      $error("text_valid: expected %0d more verdicts, actual none", expected_verdicts.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
